// ===== rtl/pbc_pkg.sv =====
// Package for the power button controller: item, configuration and mode types,
// register indexes and configuration reset values.
// Depends on nothing; every file of the block uses it by scoped names.
package pbc_pkg;

  // Input item, one per tick.
  typedef struct packed {
    logic button_pressed;
    logic shutdown_request;
    logic cpu_hold;
  } in_t;

  // Result item, one per input item.
  typedef struct packed {
    logic       power_enable;
    logic       wake_low;
    logic [2:0] mode_code;
  } out_t;

  typedef struct packed {
    logic [7:0]  glitch_count;
    logic [15:0] hold_count;
    logic [7:0]  detect_ticks;
    logic [9:0]  wake_pulse_ticks;
  } cfg_t;

  // Internal modes, the top modes first.
  typedef enum logic [3:0] {
    M_OFF       = 4'd0,
    M_SOFT      = 4'd1,
    M_ON        = 4'd2,
    M_PRESS     = 4'd3,
    M_HOLD      = 4'd4,
    M_OFF_WAIT  = 4'd5,
    M_SOFT_WAIT = 4'd6,
    M_ON_WAIT   = 4'd7,
    M_RELEASE   = 4'd8,
    M_WAKE      = 4'd9,
    M_HOLD_WAIT = 4'd10,
    M_HOLD_REL  = 4'd11
  } mode_e;

  // Top modes, as kept for the return and target of a press.
  typedef enum logic [1:0] {
    TOP_OFF  = 2'd0,
    TOP_SOFT = 2'd1,
    TOP_ON   = 2'd2
  } top_e;

  // Reported mode codes.
  localparam logic [2:0] CODE_OFF     = 3'd0;
  localparam logic [2:0] CODE_SOFT    = 3'd1;
  localparam logic [2:0] CODE_ON      = 3'd2;
  localparam logic [2:0] CODE_PRESSED = 3'd3;
  localparam logic [2:0] CODE_HOLD    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_GLITCH_COUNT     = 2'd0;
  localparam logic [1:0] REG_HOLD_COUNT       = 2'd1;
  localparam logic [1:0] REG_DETECT_TICKS     = 2'd2;
  localparam logic [1:0] REG_WAKE_PULSE_TICKS = 2'd3;

  localparam logic [7:0]  GLITCH_COUNT_RST     = 8'd10;
  localparam logic [15:0] HOLD_COUNT_RST       = 16'd2000;
  localparam logic [7:0]  DETECT_TICKS_RST     = 8'd20;
  localparam logic [9:0]  WAKE_PULSE_TICKS_RST = 10'd100;

endpackage

// ===== rtl/power_button_controller.sv =====
// Power button controller top level: mode state machine, configuration
// registers and a two-entry result buffer.
// Depends on pbc_pkg.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-------------------------
//   cfg      | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//   in       | in        | in_valid_i / in_stall_o  | in_data_i  (pbc_pkg::in_t)
//   out      | out       | out_valid_o / out_stall_i| out_data_o (pbc_pkg::out_t)
//
// One tick item is taken per clock cycle while in_stall_o is low; its state
// update is a single pass of compare and count logic, and its result is
// registered. A second result register holds one item while the output is
// stalled, so in_stall_o rises only once both result registers are full.
// Reset puts the controller in off with power and wake released.
module power_button_controller #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pbc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pbc_pkg::out_t  out_data_o
);

  localparam int CmpW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    pbc_pkg::mode_e         mode;
    pbc_pkg::top_e          ret;
    pbc_pkg::top_e          tgt;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   pwr;
    logic                   wake;
  } state_t;

  // ---------------------------------------------------------------------------
  // State update helpers, mirroring the phase entries of the controller.

  function automatic logic cnt_ge(logic [COUNT_WIDTH-1:0] c, logic [15:0] lvl);
    return CmpW'(c) >= CmpW'(lvl);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] count_toward(logic [COUNT_WIDTH-1:0] c,
                                                          logic up);
    logic [COUNT_WIDTH-1:0] r;
    r = c;
    if (up) begin
      if (c != CntMax) r = c + COUNT_WIDTH'(1);
    end else begin
      if (c != '0) r = c - COUNT_WIDTH'(1);
    end
    return r;
  endfunction

  function automatic pbc_pkg::mode_e to_mode(pbc_pkg::top_e t);
    pbc_pkg::mode_e m;
    unique case (t)
      pbc_pkg::TOP_SOFT: m = pbc_pkg::M_SOFT;
      pbc_pkg::TOP_ON:   m = pbc_pkg::M_ON;
      default:           m = pbc_pkg::M_OFF;
    endcase
    return m;
  endfunction

  function automatic state_t enter_top(state_t s, pbc_pkg::top_e t);
    state_t r;
    r = s;
    r.mode = to_mode(t);
    r.pwr  = (t == pbc_pkg::TOP_ON);
    r.wake = 1'b0;
    return r;
  endfunction

  function automatic state_t resolve_wait(state_t s, pbc_pkg::mode_e w, logic sd);
    state_t r;
    if (sd) begin
      r = enter_top(s, pbc_pkg::TOP_SOFT);
    end else if (w == pbc_pkg::M_OFF_WAIT) begin
      r = enter_top(s, pbc_pkg::TOP_OFF);
    end else begin
      r = enter_top(s, pbc_pkg::TOP_ON);
    end
    return r;
  endfunction

  function automatic state_t start_wait(state_t s, pbc_pkg::cfg_t c,
                                        pbc_pkg::mode_e w, logic sd);
    state_t r;
    r = s;
    // With no recheck delay the same tick confirms the request.
    if (c.detect_ticks == '0) begin
      r = resolve_wait(s, w, sd);
    end else begin
      r.mode = w;
      r.cnt  = '0;
    end
    return r;
  endfunction

  function automatic state_t enter_wake(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    if (c.wake_pulse_ticks == '0) begin
      r = enter_top(s, s.tgt);
    end else begin
      r.mode = pbc_pkg::M_WAKE;
      r.wake = 1'b1;
      r.cnt  = '0;
    end
    return r;
  endfunction

  function automatic state_t enter_release(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    r.mode = pbc_pkg::M_RELEASE;
    r.cnt  = COUNT_WIDTH'(1);
    if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_wake(r, c);
    return r;
  endfunction

  function automatic state_t enter_press(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    r.mode = pbc_pkg::M_PRESS;
    r.cnt  = COUNT_WIDTH'(1);
    if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_release(r, c);
    return r;
  endfunction

  function automatic state_t enter_hold_release(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    r.pwr  = 1'b0;
    r.mode = pbc_pkg::M_HOLD_REL;
    r.cnt  = COUNT_WIDTH'(1);
    if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_top(r, pbc_pkg::TOP_OFF);
    return r;
  endfunction

  function automatic state_t enter_hold_wait(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    r.wake = 1'b1;
    r.mode = pbc_pkg::M_HOLD_WAIT;
    r.cnt  = COUNT_WIDTH'(1);
    if (cnt_ge(r.cnt, c.hold_count)) r = enter_hold_release(r, c);
    return r;
  endfunction

  function automatic state_t enter_hold(state_t s, pbc_pkg::cfg_t c);
    state_t r;
    r = s;
    r.mode = pbc_pkg::M_HOLD;
    r.cnt  = COUNT_WIDTH'(1);
    if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_hold_wait(r, c);
    return r;
  endfunction

  function automatic state_t step(state_t s, pbc_pkg::cfg_t c, pbc_pkg::in_t x);
    state_t r;
    logic   btn;
    logic   sd;
    r   = s;
    btn = x.button_pressed;
    sd  = x.shutdown_request;
    unique case (s.mode)
      pbc_pkg::M_OFF, pbc_pkg::M_SOFT: begin
        r.ret = (s.mode == pbc_pkg::M_OFF) ? pbc_pkg::TOP_OFF : pbc_pkg::TOP_SOFT;
        r.tgt = pbc_pkg::TOP_ON;
        r.pwr = 1'b0;
        // A pressed button wins over a shutdown request in the same tick.
        if (btn) begin
          r = enter_press(r, c);
        end else if (s.mode == pbc_pkg::M_OFF && sd) begin
          r = start_wait(r, c, pbc_pkg::M_OFF_WAIT, sd);
        end else if (s.mode == pbc_pkg::M_SOFT && !sd) begin
          r = start_wait(r, c, pbc_pkg::M_SOFT_WAIT, sd);
        end
      end
      pbc_pkg::M_ON: begin
        r.ret = pbc_pkg::TOP_ON;
        r.tgt = pbc_pkg::TOP_OFF;
        r.pwr = 1'b1;
        if (btn) begin
          r = x.cpu_hold ? enter_hold(r, c) : enter_press(r, c);
        end else if (sd) begin
          r = start_wait(r, c, pbc_pkg::M_ON_WAIT, sd);
        end
      end
      pbc_pkg::M_OFF_WAIT, pbc_pkg::M_SOFT_WAIT, pbc_pkg::M_ON_WAIT: begin
        r.cnt = s.cnt + COUNT_WIDTH'(1);
        if (cnt_ge(r.cnt, {8'd0, c.detect_ticks})) r = resolve_wait(r, s.mode, sd);
      end
      pbc_pkg::M_PRESS: begin
        r.cnt = count_toward(s.cnt, btn);
        if (r.cnt == '0) begin
          r = enter_top(r, s.ret);
        end else if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) begin
          r = enter_release(r, c);
        end
      end
      pbc_pkg::M_RELEASE: begin
        r.cnt = count_toward(s.cnt, !btn);
        if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_wake(r, c);
      end
      pbc_pkg::M_WAKE: begin
        r.cnt = s.cnt + COUNT_WIDTH'(1);
        if (cnt_ge(r.cnt, {6'd0, c.wake_pulse_ticks})) r = enter_top(r, s.tgt);
      end
      pbc_pkg::M_HOLD: begin
        r.cnt = count_toward(s.cnt, btn);
        if (r.cnt == '0) begin
          r = enter_top(r, pbc_pkg::TOP_ON);
        end else if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) begin
          r = enter_hold_wait(r, c);
        end
      end
      pbc_pkg::M_HOLD_WAIT: begin
        r.cnt = count_toward(s.cnt, btn);
        if (r.cnt == '0) begin
          r = enter_top(r, pbc_pkg::TOP_ON);
        end else if (cnt_ge(r.cnt, c.hold_count)) begin
          r = enter_hold_release(r, c);
        end
      end
      pbc_pkg::M_HOLD_REL: begin
        r.cnt = count_toward(s.cnt, !btn);
        if (cnt_ge(r.cnt, {8'd0, c.glitch_count})) r = enter_top(r, pbc_pkg::TOP_OFF);
      end
      default: begin
        r = enter_top(r, pbc_pkg::TOP_OFF);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.

  pbc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_count     <= pbc_pkg::GLITCH_COUNT_RST;
      cfg_q.hold_count       <= pbc_pkg::HOLD_COUNT_RST;
      cfg_q.detect_ticks     <= pbc_pkg::DETECT_TICKS_RST;
      cfg_q.wake_pulse_ticks <= pbc_pkg::WAKE_PULSE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbc_pkg::REG_GLITCH_COUNT:     cfg_q.glitch_count     <= cfg_data_i[7:0];
        pbc_pkg::REG_HOLD_COUNT:       cfg_q.hold_count       <= cfg_data_i;
        pbc_pkg::REG_DETECT_TICKS:     cfg_q.detect_ticks     <= cfg_data_i[7:0];
        pbc_pkg::REG_WAKE_PULSE_TICKS: cfg_q.wake_pulse_ticks <= cfg_data_i[9:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Mode state machine.

  state_t        state_d, state_q;
  pbc_pkg::out_t res_d;
  logic          in_fire;
  logic          out_fire;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    if (in_fire) state_d = step(state_q, cfg_q, in_data_i);
  end

  // Result of the item taken this cycle, from the state it leaves behind.
  // A shutdown recheck wait reports the top mode being left.
  always_comb begin
    res_d.power_enable = state_d.pwr;
    res_d.wake_low     = state_d.wake;
    unique case (state_d.mode)
      pbc_pkg::M_OFF, pbc_pkg::M_OFF_WAIT:   res_d.mode_code = pbc_pkg::CODE_OFF;
      pbc_pkg::M_SOFT, pbc_pkg::M_SOFT_WAIT: res_d.mode_code = pbc_pkg::CODE_SOFT;
      pbc_pkg::M_ON, pbc_pkg::M_ON_WAIT:     res_d.mode_code = pbc_pkg::CODE_ON;
      pbc_pkg::M_PRESS, pbc_pkg::M_RELEASE, pbc_pkg::M_WAKE:
        res_d.mode_code = pbc_pkg::CODE_PRESSED;
      pbc_pkg::M_HOLD, pbc_pkg::M_HOLD_WAIT, pbc_pkg::M_HOLD_REL:
        res_d.mode_code = pbc_pkg::CODE_HOLD;
      default: res_d.mode_code = pbc_pkg::CODE_OFF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= pbc_pkg::M_OFF;
      state_q.ret  <= pbc_pkg::TOP_OFF;
      state_q.tgt  <= pbc_pkg::TOP_ON;
      state_q.cnt  <= '0;
      state_q.pwr  <= 1'b0;
      state_q.wake <= 1'b0;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer: output register plus one skid register.

  pbc_pkg::out_t out_q, skid_q;
  logic          out_valid_q, skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pbc_checker.sv =====
// Port-level checker for the power button controller, with its bind statement.
// Depends on pbc_pkg and on the port list of power_button_controller.
module pbc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input pbc_pkg::out_t out_data_o
);

  // The input side stalls only while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // The spare result register fills only behind a stalled output.
  a_stall_after_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without a stalled result");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Power is on only in on mode or during a press from it.
  a_power_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.power_enable |->
      out_data_o.mode_code == pbc_pkg::CODE_ON ||
      out_data_o.mode_code == pbc_pkg::CODE_PRESSED ||
      out_data_o.mode_code == pbc_pkg::CODE_HOLD)
    else $error("power enabled in an off mode");

  // The wake line is driven only while a press is being handled.
  a_wake_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.wake_low |->
      out_data_o.mode_code == pbc_pkg::CODE_PRESSED ||
      out_data_o.mode_code == pbc_pkg::CODE_HOLD)
    else $error("wake line driven outside a press");

endmodule

bind power_button_controller pbc_checker u_pbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for power_button_controller: a queue-fed driver, a
// result monitor and an in-line prediction of the controller's tick behavior.
// Depends on pbc_pkg and the power_button_controller RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 100_000;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH, GAP_PRESSURE} gap_e;
  typedef enum int {
    SC_PRESS, SC_HOLD, SC_HOLD_FULL, SC_SHUTDOWN, SC_RECHECK_FAIL, SC_BOUNCE, SC_NOISE
  } scen_e;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_idx_i = '0;
  logic [15:0]   cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  pbc_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  pbc_pkg::out_t out_data_o;

  power_button_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  pbc_pkg::in_t  pending_ticks[$];
  pbc_pkg::out_t awaited_outputs[$];
  pbc_pkg::out_t want_res;

  gap_e gap_mode = GAP_NONE;
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  int   holdoff_cnt = 0;
  int   phase_items = 0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;
  logic sd_level;

  // Predicted controller state and its copy of the configuration.
  pbc_pkg::mode_e cur_mode;
  pbc_pkg::top_e  back_top;
  pbc_pkg::top_e  goal_top;
  logic [15:0]    step_cnt;
  logic           pwr_on;
  logic           wake_on;
  logic [15:0]    lvl_glitch;
  logic [15:0]    lvl_hold;
  logic [15:0]    lvl_detect;
  logic [15:0]    lvl_wake;

  function automatic pbc_pkg::mode_e top_mode(pbc_pkg::top_e t);
    return pbc_pkg::mode_e'({2'b00, t});
  endfunction

  function automatic void go_top(pbc_pkg::mode_e m);
    cur_mode = m;
    pwr_on = (m == pbc_pkg::M_ON);
    wake_on = 1'b0;
  endfunction

  function automatic void count_step(logic up);
    if (up) begin
      if (step_cnt != 16'hFFFF) step_cnt = step_cnt + 16'd1;
    end else if (step_cnt != 16'd0) begin
      step_cnt = step_cnt - 16'd1;
    end
  endfunction

  function automatic void settle_recheck(pbc_pkg::mode_e w, logic sd);
    if (sd) go_top(pbc_pkg::M_SOFT);
    else if (w == pbc_pkg::M_OFF_WAIT) go_top(pbc_pkg::M_OFF);
    else go_top(pbc_pkg::M_ON);
  endfunction

  function automatic void begin_recheck(pbc_pkg::mode_e w, logic sd);
    if (lvl_detect == 16'd0) begin
      settle_recheck(w, sd);
    end else begin
      cur_mode = w;
      step_cnt = 16'd0;
    end
  endfunction

  function automatic void begin_wake();
    if (lvl_wake == 16'd0) begin
      go_top(top_mode(goal_top));
    end else begin
      cur_mode = pbc_pkg::M_WAKE;
      wake_on = 1'b1;
      step_cnt = 16'd0;
    end
  endfunction

  function automatic void begin_release();
    cur_mode = pbc_pkg::M_RELEASE;
    step_cnt = 16'd1;
    if (step_cnt >= lvl_glitch) begin_wake();
  endfunction

  function automatic void begin_press();
    cur_mode = pbc_pkg::M_PRESS;
    step_cnt = 16'd1;
    if (step_cnt >= lvl_glitch) begin_release();
  endfunction

  function automatic void begin_hold_release();
    pwr_on = 1'b0;
    cur_mode = pbc_pkg::M_HOLD_REL;
    step_cnt = 16'd1;
    if (step_cnt >= lvl_glitch) go_top(pbc_pkg::M_OFF);
  endfunction

  function automatic void begin_hold_wait();
    wake_on = 1'b1;
    cur_mode = pbc_pkg::M_HOLD_WAIT;
    step_cnt = 16'd1;
    if (step_cnt >= lvl_hold) begin_hold_release();
  endfunction

  // Advances the predicted state by one tick item and returns its result.
  function automatic pbc_pkg::out_t advance_controller(pbc_pkg::in_t t);
    pbc_pkg::out_t r;
    case (cur_mode)
      pbc_pkg::M_OFF, pbc_pkg::M_SOFT: begin
        back_top = pbc_pkg::top_e'(cur_mode[1:0]);
        goal_top = pbc_pkg::TOP_ON;
        pwr_on = 1'b0;
        if (t.button_pressed) begin
          begin_press();
        end else if (cur_mode == pbc_pkg::M_OFF && t.shutdown_request) begin
          begin_recheck(pbc_pkg::M_OFF_WAIT, 1'b1);
        end else if (cur_mode == pbc_pkg::M_SOFT && !t.shutdown_request) begin
          begin_recheck(pbc_pkg::M_SOFT_WAIT, 1'b0);
        end
      end
      pbc_pkg::M_ON: begin
        back_top = pbc_pkg::TOP_ON;
        goal_top = pbc_pkg::TOP_OFF;
        pwr_on = 1'b1;
        if (t.button_pressed) begin
          if (t.cpu_hold) begin
            cur_mode = pbc_pkg::M_HOLD;
            step_cnt = 16'd1;
            if (step_cnt >= lvl_glitch) begin_hold_wait();
          end else begin
            begin_press();
          end
        end else if (t.shutdown_request) begin
          begin_recheck(pbc_pkg::M_ON_WAIT, 1'b1);
        end
      end
      pbc_pkg::M_OFF_WAIT, pbc_pkg::M_SOFT_WAIT, pbc_pkg::M_ON_WAIT: begin
        step_cnt = step_cnt + 16'd1;
        if (step_cnt >= lvl_detect) settle_recheck(cur_mode, t.shutdown_request);
      end
      pbc_pkg::M_PRESS: begin
        count_step(t.button_pressed);
        if (step_cnt == 16'd0) go_top(top_mode(back_top));
        else if (step_cnt >= lvl_glitch) begin_release();
      end
      pbc_pkg::M_RELEASE: begin
        count_step(!t.button_pressed);
        if (step_cnt >= lvl_glitch) begin_wake();
      end
      pbc_pkg::M_WAKE: begin
        step_cnt = step_cnt + 16'd1;
        if (step_cnt >= lvl_wake) go_top(top_mode(goal_top));
      end
      pbc_pkg::M_HOLD: begin
        count_step(t.button_pressed);
        if (step_cnt == 16'd0) go_top(pbc_pkg::M_ON);
        else if (step_cnt >= lvl_glitch) begin_hold_wait();
      end
      pbc_pkg::M_HOLD_WAIT: begin
        count_step(t.button_pressed);
        if (step_cnt == 16'd0) go_top(pbc_pkg::M_ON);
        else if (step_cnt >= lvl_hold) begin_hold_release();
      end
      pbc_pkg::M_HOLD_REL: begin
        count_step(!t.button_pressed);
        if (step_cnt >= lvl_glitch) go_top(pbc_pkg::M_OFF);
      end
      default: begin
        go_top(pbc_pkg::M_OFF);
      end
    endcase

    // A recheck wait reports the top mode it is leaving.
    case (cur_mode)
      pbc_pkg::M_OFF, pbc_pkg::M_OFF_WAIT:   r.mode_code = pbc_pkg::CODE_OFF;
      pbc_pkg::M_SOFT, pbc_pkg::M_SOFT_WAIT: r.mode_code = pbc_pkg::CODE_SOFT;
      pbc_pkg::M_ON, pbc_pkg::M_ON_WAIT:     r.mode_code = pbc_pkg::CODE_ON;
      pbc_pkg::M_PRESS, pbc_pkg::M_RELEASE, pbc_pkg::M_WAKE:
        r.mode_code = pbc_pkg::CODE_PRESSED;
      pbc_pkg::M_HOLD, pbc_pkg::M_HOLD_WAIT, pbc_pkg::M_HOLD_REL:
        r.mode_code = pbc_pkg::CODE_HOLD;
      default: r.mode_code = pbc_pkg::CODE_OFF;
    endcase
    r.power_enable = pwr_on;
    r.wake_low = wake_on;
    return r;
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic void push_tick(logic b, logic s, logic h);
    pending_ticks.push_back(pbc_pkg::in_t'({b, s, h}));
    phase_items++;
  endfunction

  // Appends one well-formed (or deliberately broken) tick sequence sized from
  // the configuration that is in force.
  function automatic void add_scenario(scen_e kind);
    int   g;
    int   h;
    int   n;
    logic hb;
    g = int'(lvl_glitch);
    h = int'(lvl_hold);
    case (kind)
      SC_PRESS, SC_HOLD, SC_HOLD_FULL: begin
        hb = (kind == SC_PRESS) ? ($urandom_range(3) == 0) : 1'b1;
        if (kind == SC_PRESS) n = g + int'($urandom_range(3));
        else if (kind == SC_HOLD) n = g + int'($urandom_range((h > 64 ? 64 : h) + 3));
        else n = g + h + int'($urandom_range(2));
        repeat (n) push_tick(1'b1, sd_level, hb);
        n = g + int'(lvl_wake) + int'($urandom_range(3));
        repeat (n) push_tick(1'b0, sd_level, rand_bit());
      end
      SC_SHUTDOWN: begin
        sd_level = ~sd_level;
        n = int'(lvl_detect) + int'($urandom_range(1, 3));
        repeat (n) push_tick(1'b0, sd_level, rand_bit());
      end
      SC_RECHECK_FAIL: begin
        push_tick(1'b0, ~sd_level, rand_bit());
        n = int'(lvl_detect) + int'($urandom_range(1, 2));
        repeat (n) push_tick(1'b0, sd_level, rand_bit());
      end
      SC_BOUNCE: begin
        n = int'($urandom_range(1, 2 * g + 4));
        repeat (n) push_tick(($urandom_range(9) < 6), sd_level, rand_bit());
      end
      default: begin
        n = int'($urandom_range(1, 8));
        repeat (n) push_tick(rand_bit(), rand_bit(), rand_bit());
      end
    endcase
  endfunction

  // Returns once no item is queued, offered or awaiting its result.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || awaited_outputs.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pbc_pkg::REG_GLITCH_COUNT: lvl_glitch = {8'd0, val[7:0]};
      pbc_pkg::REG_HOLD_COUNT:   lvl_hold = val;
      pbc_pkg::REG_DETECT_TICKS: lvl_detect = {8'd0, val[7:0]};
      default:                   lvl_wake = {6'd0, val[9:0]};
    endcase
  endtask

  task automatic set_config(int g, int h, int d, int w);
    wait_idle();
    write_reg(pbc_pkg::REG_GLITCH_COUNT, 16'(g));
    write_reg(pbc_pkg::REG_HOLD_COUNT, 16'(h));
    write_reg(pbc_pkg::REG_DETECT_TICKS, 16'(d));
    write_reg(pbc_pkg::REG_WAKE_PULSE_TICKS, 16'(w));
  endtask

  task automatic begin_fill(gap_e g);
    @(negedge clk_i);
    gap_mode = g;
    send_gap_pct = (g == GAP_SEND) ? 58 : (g == GAP_BOTH) ? 30 : 0;
    recv_gap_pct = (g == GAP_RECV) ? 58 : (g == GAP_BOTH) ? 30 : 0;
    phase_items = 0;
  endtask

  task automatic fill_random(int count);
    int r;
    while (phase_items < count) begin
      r = int'($urandom_range(99));
      if (r < 30) begin
        add_scenario(SC_PRESS);
      end else if (r < 42) begin
        add_scenario(SC_HOLD);
      end else if (r < 45) begin
        if (lvl_hold > 16'd64) add_scenario(SC_HOLD);
        else add_scenario(SC_HOLD_FULL);
      end else if (r < 60) begin
        add_scenario(SC_SHUTDOWN);
      end else if (r < 68) begin
        add_scenario(SC_RECHECK_FAIL);
      end else if (r < 85) begin
        add_scenario(SC_BOUNCE);
      end else begin
        add_scenario(SC_NOISE);
      end
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender: offers queued tick items and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) awaited_outputs.push_back(advance_controller(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_ticks.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall; under pressure it holds off for long stretches so that
  // the result buffer fills and the input side stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      holdoff_cnt <= 0;
    end else if (gap_mode == GAP_PRESSURE) begin
      out_stall_i <= (holdoff_cnt % 400) < 120;
      holdoff_cnt <= holdoff_cnt + 1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_gap_pct;
      holdoff_cnt <= 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected result: power %0b wake %0b mode %0d", $time,
                 out_data_o.power_enable, out_data_o.wake_low, out_data_o.mode_code);
        mismatch_cnt++;
      end else begin
        want_res = awaited_outputs.pop_front();
        if (out_data_o.power_enable !== want_res.power_enable ||
            out_data_o.wake_low !== want_res.wake_low ||
            out_data_o.mode_code !== want_res.mode_code) begin
          $display("%0t: result mismatch: expected power %0b wake %0b mode %0d", $time,
                   want_res.power_enable, want_res.wake_low, want_res.mode_code);
          $display("%0t:                  got      power %0b wake %0b mode %0d", $time,
                   out_data_o.power_enable, out_data_o.wake_low, out_data_o.mode_code);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_outputs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    gap_e small_gaps[5];
    small_gaps = '{GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH, GAP_BOTH};
    cur_mode = pbc_pkg::M_OFF;
    back_top = pbc_pkg::TOP_OFF;
    goal_top = pbc_pkg::TOP_ON;
    step_cnt = 16'd0;
    pwr_on = 1'b0;
    wake_on = 1'b0;
    lvl_glitch = 16'(pbc_pkg::GLITCH_COUNT_RST);
    lvl_hold = pbc_pkg::HOLD_COUNT_RST;
    lvl_detect = 16'(pbc_pkg::DETECT_TICKS_RST);
    lvl_wake = 16'(pbc_pkg::WAKE_PULSE_TICKS_RST);
    sd_level = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: presses that die out before qualifying, and a
    // press that wins over a shutdown request in the same tick.
    begin_fill(GAP_NONE);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);

    // Lowest levels: every phase completes within the tick that starts it,
    // the wake line is never driven and every recheck confirms at once.
    set_config(1, 1, 0, 0);
    begin_fill(GAP_NONE);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b1, 1'b0);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);

    foreach (small_gaps[i]) begin
      set_config($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(0, 6),
                 $urandom_range(0, 8));
      begin_fill(small_gaps[i]);
      fill_random(100);
    end

    // Moderate levels, with one full held press while the receiver keeps
    // holding off.
    set_config(10, 200, 20, 100);
    begin_fill(GAP_PRESSURE);
    sd_level = 1'b0;
    add_scenario(SC_PRESS);
    add_scenario(SC_HOLD_FULL);
    fill_random(500);

    // Highest levels: a long shutdown recheck that confirms and one that fails.
    set_config(255, 65535, 255, 1023);
    begin_fill(GAP_NONE);
    sd_level = 1'b0;
    add_scenario(SC_SHUTDOWN);
    add_scenario(SC_RECHECK_FAIL);

    set_config($urandom_range(1, 6), $urandom_range(1, 24), $urandom_range(0, 6),
               $urandom_range(0, 8));
    begin_fill(GAP_SEND);
    fill_random(150);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
